[hw/rtl/hsgm_pkg.sv]
// ----------------------------------------------------------------------------
// hsgm_pkg
// Shared types and codes for the hue selective grayscale mixer.
// ----------------------------------------------------------------------------
package hsgm_pkg;

  typedef logic [15:0] sample_t;
  typedef logic [12:0] tindex_t;
  typedef logic [16:0] weight_t;

  localparam int CFG_IW = 3;
  localparam int CFG_DW = 48;

  localparam logic [CFG_IW-1:0] REG_WEIGHT_RED   = 3'd0;
  localparam logic [CFG_IW-1:0] REG_WEIGHT_GREEN = 3'd1;
  localparam logic [CFG_IW-1:0] REG_WEIGHT_BLUE  = 3'd2;
  localparam logic [CFG_IW-1:0] REG_MIX_IN_GAMMA = 3'd3;
  localparam logic [CFG_IW-1:0] REG_HUE_GAINS    = 3'd4;

  localparam weight_t RST_WEIGHT_RED   = 17'd13933;
  localparam weight_t RST_WEIGHT_GREEN = 17'd46871;
  localparam weight_t RST_WEIGHT_BLUE  = 17'd4732;

  localparam logic OP_CONVERT     = 1'b0;
  localparam logic OP_TABLE_WRITE = 1'b1;

  // Channel that holds the maximum, for the hue sector.
  localparam logic [1:0] SEC_RED   = 2'd0;
  localparam logic [1:0] SEC_GREEN = 2'd1;
  localparam logic [1:0] SEC_BLUE  = 2'd2;

  // floor(2^23 / 100); the estimate is at most one below the true quotient.
  localparam logic [16:0] RECIP_100   = 17'd83886;
  localparam int          RECIP_SHIFT = 23;

endpackage

[hw/rtl/hsgm_in_if.sv]
// ----------------------------------------------------------------------------
// hsgm_in_if
// Input channel: one pixel or one tone table write per item.
// ----------------------------------------------------------------------------
interface hsgm_in_if;
  logic             valid;
  logic             ready;
  logic             operation;
  hsgm_pkg::sample_t red_linear;
  hsgm_pkg::sample_t green_linear;
  hsgm_pkg::sample_t blue_linear;
  hsgm_pkg::tindex_t table_index;
  hsgm_pkg::sample_t table_value;

  modport source (output valid, operation, red_linear, green_linear, blue_linear,
                  table_index, table_value, input ready);
  modport sink   (input valid, operation, red_linear, green_linear, blue_linear,
                  table_index, table_value, output ready);
endinterface

[hw/rtl/hsgm_out_if.sv]
// ----------------------------------------------------------------------------
// hsgm_out_if
// Result channel: one grey value per converted pixel.
// ----------------------------------------------------------------------------
interface hsgm_out_if;
  logic              valid;
  logic              ready;
  hsgm_pkg::sample_t grey_out;

  modport source (output valid, grey_out, input ready);
  modport sink   (input valid, grey_out, output ready);
endinterface

[hw/rtl/hue_selective_grayscale_mixer.sv]
// ----------------------------------------------------------------------------
// hue_selective_grayscale_mixer
// Linear RGB to 16-bit grey with channel weights, hue band gains and a tone table.
// ----------------------------------------------------------------------------
// The block takes one item per clock while the result side does not stall and
// presents a pixel's grey on the result port from the result register, which
// follows 18 pipeline stages, among them the two 17-bit quotient dividers
// (saturation and hue). A stall on the result side freezes the whole pipeline,
// and ready drops only while a result waits. Tone table writes travel down the
// same pipeline and land at the stage that reads the table, so they take effect
// in item order. The sRGB encoding ROM is built at elaboration from TABLE_STEPS.
// The tone table has no reset and must be loaded before pixels are sent.
module hue_selective_grayscale_mixer #(
  parameter int TABLE_STEPS = 4096
) (
  input  logic                          clk,
  input  logic                          rst_n,
  hsgm_in_if.sink                       in_px,
  hsgm_out_if.source                    out_px,
  input  logic                          cfg_we,
  input  logic [hsgm_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [hsgm_pkg::CFG_DW-1:0]   cfg_data
);
  import hsgm_pkg::*;

  localparam int IW  = $clog2(TABLE_STEPS + 1);
  localparam int NST = 18;
  localparam longint DEN = 64'sd1000 << 20;
  localparam longint DEN_HALF = DEN / 2;
  localparam longint unsigned LIN_DEN = 64'd200 * TABLE_STEPS;

  typedef logic [15:0] rom_t [TABLE_STEPS+1];
  typedef struct packed {
    logic [15:0] rem;
    logic [17:0] quo;
  } div_t;

  // ---------------------------------------------------------------- ROM build
  function automatic longint unsigned icbrt(longint unsigned v);
    longint unsigned lo, hi, m;
    lo = 0;
    hi = 64'd1 << 21;
    for (int k = 0; k < 22; k++) begin
      if (hi - lo > 1) begin
        m = (lo + hi) >> 1;
        if (m * m * m <= v) lo = m; else hi = m;
      end
    end
    return lo;
  endfunction

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned lo, hi, m;
    lo = 0;
    hi = 64'd1 << 21;
    for (int k = 0; k < 22; k++) begin
      if (hi - lo > 1) begin
        m = (lo + hi) >> 1;
        if (m * m <= v) lo = m; else hi = m;
      end
    end
    return lo;
  endfunction

  function automatic logic [15:0] rom_entry(longint unsigned i);
    longint unsigned v, xq, c, s1, s2, p;
    longint num, vv;
    logic [15:0] rv;
    if (i * 64'd10000000 <= 64'd31308 * TABLE_STEPS) begin
      v = (i * 64'd1292 * 64'd65535 * 64'd2 + 64'd100 * TABLE_STEPS) / LIN_DEN;
      rv = (v > 64'd65535) ? 16'hFFFF : v[15:0];
    end else begin
      xq = ((i << 44) / TABLE_STEPS) << 16;
      c  = icbrt(xq);
      s1 = isqrt(c << 20);
      s2 = isqrt(s1 << 20);
      p  = (c * s2 + (64'd1 << 19)) >> 20;
      num = (longint'(64'd1055 * p) - 64'sd55 * (64'sd1 << 20)) * 64'sd65535;
      if (num <= 0) begin
        rv = 16'd0;
      end else begin
        vv = (num + DEN_HALF) / DEN;
        rv = (vv > 64'sd65535) ? 16'hFFFF : vv[15:0];
      end
    end
    return rv;
  endfunction

  function automatic rom_t build_rom();
    rom_t r;
    for (int i = 0; i <= TABLE_STEPS; i++) r[i] = rom_entry(longint'(i));
    return r;
  endfunction

  localparam rom_t SRGB_ROM = build_rom();

  // ----------------------------------------------------------------- helpers
  // Nearest grid point of a Q0.16 value: round(v * TABLE_STEPS / 65535).
  function automatic logic [IW-1:0] grid_idx(logic [15:0] v);
    logic [32:0] m;
    logic [17:0] s;
    logic [17:0] q;
    logic [1:0]  c;
    m = 33'(v) * 33'(TABLE_STEPS) + 33'd32767;
    s = 18'(m[32:16]) + 18'(m[15:0]);
    c = (s >= 18'd131070) ? 2'd2 : ((s >= 18'd65535) ? 2'd1 : 2'd0);
    q = 18'(m[32:16]) + 18'(c);
    if (q > 18'(TABLE_STEPS)) q = 18'(TABLE_STEPS);
    return q[IW-1:0];
  endfunction

  function automatic div_t div_steps(div_t din, logic [15:0] d, int n);
    div_t        o;
    logic [16:0] r2;
    o = din;
    for (int k = 0; k < 3; k++) begin
      if (k < n) begin
        r2 = {o.rem, 1'b0};
        if (r2 >= {1'b0, d}) begin
          o.rem = 16'(r2 - {1'b0, d});
          o.quo = {o.quo[16:0], 1'b1};
        end else begin
          o.rem = r2[15:0];
          o.quo = {o.quo[16:0], 1'b0};
        end
      end
    end
    return o;
  endfunction

  function automatic logic signed [7:0] band_gain(logic [47:0] g, logic [2:0] k);
    logic signed [7:0] b;
    b = g[{k, 3'b000} +: 8];
    if (b > 8'sd100) b = 8'sd100;
    if (b < -8'sd100) b = -8'sd100;
    return b;
  endfunction

  // ----------------------------------------------------------- configuration
  weight_t     wr_r, wg_r, wb_r;
  logic        mix_gamma_r;
  logic [47:0] gains_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r        <= RST_WEIGHT_RED;
      wg_r        <= RST_WEIGHT_GREEN;
      wb_r        <= RST_WEIGHT_BLUE;
      mix_gamma_r <= 1'b0;
      gains_r     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WEIGHT_RED:   wr_r        <= cfg_data[16:0];
        REG_WEIGHT_GREEN: wg_r        <= cfg_data[16:0];
        REG_WEIGHT_BLUE:  wb_r        <= cfg_data[16:0];
        REG_MIX_IN_GAMMA: mix_gamma_r <= cfg_data[0];
        REG_HUE_GAINS:    gains_r     <= cfg_data[47:0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------ flow control
  logic adv;
  logic out_valid_r;
  logic [15:0] out_grey_r;
  logic vld_r [1:NST];
  logic op_r  [1:NST];
  tindex_t tidx_r [1:NST];
  sample_t tval_r [1:NST];

  assign adv          = !out_valid_r || out_px.ready;
  assign in_px.ready  = adv;
  assign out_px.valid = out_valid_r;
  assign out_px.grey_out = out_grey_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 1; k <= NST; k++) vld_r[k] <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r[1] <= in_px.valid;
      for (int k = 2; k <= NST; k++) vld_r[k] <= vld_r[k-1];
      out_valid_r <= vld_r[NST] && (op_r[NST] == OP_CONVERT);
    end
  end

  // ------------------------------------------------------------- datapath
  logic [IW-1:0] idxr1_r, idxg1_r, idxb1_r;
  logic [32:0]   pr1_r, pg1_r, pb1_r;
  logic [15:0]   rs2_r, gs2_r, bs2_r, lin2_r;
  logic [IW-1:0] lidx3_r;
  logic [32:0]   qr3_r, qg3_r, qb3_r;
  logic [15:0]   mx3_r, dl3_r, hx3_r;
  logic [1:0]    sec3_r;
  logic          neg3_r;
  logic [15:0]   ylin4_r;
  logic [17:0]   gam4_r;
  div_t          sdv_r [0:6];
  div_t          hdv_r [0:6];
  logic [15:0]   sd_r  [0:6];
  logic [15:0]   hd_r  [0:6];
  logic [1:0]    sec_r [0:6];
  logic          neg_r [0:6];
  logic          zmx_r [0:6];
  logic          zdl_r [0:6];
  logic [17:0]   base_r [5:17];
  logic [16:0]   sat_r  [11:13];
  logic [18:0]   h11_r;
  logic signed [25:0] p0_12_r, p1_12_r, a13_r;
  logic signed [43:0] as14_r;
  logic [22:0]   y15_r, y16_r;
  logic          neg15_r, neg16_r;
  logic [16:0]   qe16_r;
  logic [15:0]   grey17_r;
  logic [IW-1:0] gidx18_r;
  logic [15:0]   tone_mem [TABLE_STEPS+1];

  // Stage-local combinational values.
  logic [15:0]        mx_c, mn_c;
  logic [1:0]         sec_c;
  logic signed [16:0] num_c;
  logic [34:0]        lsum_c, gsum_c;
  logic [18:0]        lin_c;
  logic [16:0]        sq_c, hq_c;
  logic [18:0]        h_c;
  logic [2:0]         seg_c, segn_c;
  logic [15:0]        t_c;
  logic [42:0]        mag_c;
  logic [58:0]        m_c;
  logic [23:0]        rem_c;
  logic [16:0]        qf_c;
  logic signed [19:0] g_c;
  logic [16:0]        tidx_ext_c;

  always_comb begin
    lsum_c = 35'(pr1_r) + 35'(pg1_r) + 35'(pb1_r) + 35'd32768;
    lin_c  = lsum_c[34:16];

    mx_c = rs2_r;
    if (gs2_r > mx_c) mx_c = gs2_r;
    if (bs2_r > mx_c) mx_c = bs2_r;
    mn_c = rs2_r;
    if (gs2_r < mn_c) mn_c = gs2_r;
    if (bs2_r < mn_c) mn_c = bs2_r;
    if (mx_c == rs2_r) sec_c = SEC_RED;
    else if (mx_c == gs2_r) sec_c = SEC_GREEN;
    else sec_c = SEC_BLUE;
    case (sec_c)
      SEC_RED:   num_c = signed'({1'b0, gs2_r}) - signed'({1'b0, bs2_r});
      SEC_GREEN: num_c = signed'({1'b0, bs2_r}) - signed'({1'b0, rs2_r});
      default:   num_c = signed'({1'b0, rs2_r}) - signed'({1'b0, gs2_r});
    endcase

    gsum_c = 35'(qr3_r) + 35'(qg3_r) + 35'(qb3_r) + 35'd32768;

    // Round the doubled quotients to nearest.
    sq_c = 17'((19'(sdv_r[6].quo) + 19'd1) >> 1);
    hq_c = 17'((19'(hdv_r[6].quo) + 19'd1) >> 1);
    if (zdl_r[6]) begin
      h_c = '0;
    end else begin
      case (sec_r[6])
        SEC_RED:   h_c = (neg_r[6] && hq_c != '0) ? 19'd393216 - 19'(hq_c) : 19'(hq_c);
        SEC_GREEN: h_c = neg_r[6] ? 19'd131072 - 19'(hq_c) : 19'd131072 + 19'(hq_c);
        default:   h_c = neg_r[6] ? 19'd262144 - 19'(hq_c) : 19'd262144 + 19'(hq_c);
      endcase
    end

    seg_c  = h11_r[18:16];
    segn_c = (seg_c == 3'd5) ? 3'd0 : seg_c + 3'd1;
    t_c    = h11_r[15:0];

    mag_c = as14_r[43] ? 43'(-as14_r) : 43'(as14_r);
    m_c   = {mag_c, 16'b0} - {16'b0, mag_c};

    rem_c = 24'(y16_r) - 24'(qe16_r) * 24'd100;
    qf_c  = qe16_r + ((rem_c >= 24'd100) ? 17'd1 : 17'd0);
    g_c   = signed'({2'b00, base_r[16]})
          + (neg16_r ? -signed'({3'b000, qf_c}) : signed'({3'b000, qf_c}));

    tidx_ext_c = 17'(tidx_r[NST]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // Stage 1: grid indices and linear mix products.
      op_r[1]   <= in_px.operation;
      tidx_r[1] <= in_px.table_index;
      tval_r[1] <= in_px.table_value;
      for (int k = 2; k <= NST; k++) begin
        op_r[k]   <= op_r[k-1];
        tidx_r[k] <= tidx_r[k-1];
        tval_r[k] <= tval_r[k-1];
      end
      idxr1_r <= grid_idx(in_px.red_linear);
      idxg1_r <= grid_idx(in_px.green_linear);
      idxb1_r <= grid_idx(in_px.blue_linear);
      pr1_r   <= 33'(wr_r) * 33'(in_px.red_linear);
      pg1_r   <= 33'(wg_r) * 33'(in_px.green_linear);
      pb1_r   <= 33'(wb_r) * 33'(in_px.blue_linear);

      // Stage 2: sRGB lookups and clamped linear mix.
      rs2_r  <= SRGB_ROM[idxr1_r];
      gs2_r  <= SRGB_ROM[idxg1_r];
      bs2_r  <= SRGB_ROM[idxb1_r];
      lin2_r <= (lin_c > 19'd65535) ? 16'hFFFF : lin_c[15:0];

      // Stage 3: max, min, hue numerator and luma products.
      lidx3_r <= grid_idx(lin2_r);
      mx3_r   <= mx_c;
      dl3_r   <= mx_c - mn_c;
      sec3_r  <= sec_c;
      neg3_r  <= num_c[16];
      hx3_r   <= num_c[16] ? 16'(-num_c) : num_c[15:0];
      qr3_r   <= 33'(wr_r) * 33'(rs2_r);
      qg3_r   <= 33'(wg_r) * 33'(gs2_r);
      qb3_r   <= 33'(wb_r) * 33'(bs2_r);

      // Stage 4: encoded linear mix, luma sum, first quotient bit.
      ylin4_r <= SRGB_ROM[lidx3_r];
      gam4_r  <= gsum_c[33:16];
      sdv_r[0].quo <= {17'b0, dl3_r >= mx3_r};
      sdv_r[0].rem <= (dl3_r >= mx3_r) ? dl3_r - mx3_r : dl3_r;
      hdv_r[0].quo <= {17'b0, hx3_r >= dl3_r};
      hdv_r[0].rem <= (hx3_r >= dl3_r) ? hx3_r - dl3_r : hx3_r;
      sd_r[0]  <= mx3_r;
      hd_r[0]  <= dl3_r;
      sec_r[0] <= sec3_r;
      neg_r[0] <= neg3_r;
      zmx_r[0] <= (mx3_r == '0);
      zdl_r[0] <= (dl3_r == '0);

      // Stages 5 to 10: three quotient bits a stage, two in stage 10, 17 in all.
      for (int j = 1; j <= 6; j++) begin
        sdv_r[j] <= div_steps(sdv_r[j-1], sd_r[j-1], (j < 6) ? 3 : 2);
        hdv_r[j] <= div_steps(hdv_r[j-1], hd_r[j-1], (j < 6) ? 3 : 2);
        sd_r[j]  <= sd_r[j-1];
        hd_r[j]  <= hd_r[j-1];
        sec_r[j] <= sec_r[j-1];
        neg_r[j] <= neg_r[j-1];
        zmx_r[j] <= zmx_r[j-1];
        zdl_r[j] <= zdl_r[j-1];
      end
      base_r[5] <= mix_gamma_r ? gam4_r : {2'b00, ylin4_r};
      for (int k = 6; k <= 17; k++) base_r[k] <= base_r[k-1];

      // Stage 11: saturation and hue position.
      sat_r[11] <= zmx_r[6] ? 17'd0 : sq_c;
      h11_r     <= h_c;
      sat_r[12] <= sat_r[11];
      sat_r[13] <= sat_r[12];

      // Stage 12: band gain products.
      p0_12_r <= 26'(band_gain(gains_r, seg_c) * signed'({1'b0, 17'(18'd65536 - 18'(t_c))}));
      p1_12_r <= 26'(band_gain(gains_r, segn_c) * signed'({2'b00, t_c}));

      // Stages 13 and 14: interpolated gain, scaled by saturation.
      a13_r  <= p0_12_r + p1_12_r;
      as14_r <= 44'(a13_r * signed'({1'b0, sat_r[13]}));

      // Stage 15: times 65535, then the 2^32 part of the divide with rounding.
      y15_r   <= 23'(m_c[58:32]) + 23'd50;
      neg15_r <= as14_r[43];

      // Stage 16: reciprocal estimate of the divide by 100.
      qe16_r  <= 17'((40'(y15_r) * 40'(RECIP_100)) >> RECIP_SHIFT);
      y16_r   <= y15_r;
      neg16_r <= neg15_r;

      // Stage 17: correct the quotient, add the offset, clamp.
      if (g_c < 0) grey17_r <= 16'd0;
      else if (g_c > 20'sd65535) grey17_r <= 16'hFFFF;
      else grey17_r <= g_c[15:0];

      // Stage 18: tone table index.
      gidx18_r <= grid_idx(grey17_r);

      // Output stage: tone table read.
      out_grey_r <= tone_mem[gidx18_r];
      if (vld_r[NST] && op_r[NST] == OP_TABLE_WRITE
          && tidx_ext_c <= 17'(TABLE_STEPS)) begin
        tone_mem[tidx_ext_c[IW-1:0]] <= tval_r[NST];
      end
    end
  end

endmodule

[hw/rtl/hsgm_check.sv]
// ----------------------------------------------------------------------------
// hsgm_check
// Port-level checks of the mixer's handshake behavior.
// ----------------------------------------------------------------------------
module hsgm_check (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_grey
);
  import hsgm_pkg::*;

  // The pipeline moves whenever the result register is free or being taken.
  a_ready_tracks_out: assert property (@(posedge clk) disable iff (rst_n !== 1'b1)
    1'b1 |-> (in_ready == (!out_valid || out_ready)))
    else $error("input ready does not follow the result side");

  a_hold_result: assert property (@(posedge clk) disable iff (rst_n !== 1'b1)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_grey)))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result shown right after reset");

endmodule

bind hue_selective_grayscale_mixer hsgm_check u_hsgm_check (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_px.ready),
  .out_valid (out_px.valid),
  .out_ready (out_px.ready),
  .out_grey  (out_px.grey_out)
);

[verif/hue_selective_grayscale_mixer_tb.sv]
// ----------------------------------------------------------------------------
// hue_selective_grayscale_mixer_tb
// Self-checking testbench. The tone table is loaded first, then directed and
// random pixels run under several register settings. Each grey is predicted
// when its item is accepted and compared with the next result in order.
// ----------------------------------------------------------------------------
module hue_selective_grayscale_mixer_tb;
  import hsgm_pkg::*;

  localparam int STEPS = 4096;
  localparam int LATENCY = 19;

  typedef struct {
    logic    operation;
    sample_t red;
    sample_t green;
    sample_t blue;
    tindex_t tindex;
    sample_t tvalue;
  } pixel_item_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IW-1:0] cfg_index;
  logic [CFG_DW-1:0] cfg_data;

  hsgm_in_if in_bus ();
  hsgm_out_if out_bus ();

  hue_selective_grayscale_mixer #(.TABLE_STEPS(STEPS)) DUT (
    .clk(clk), .rst_n(rst_n), .in_px(in_bus.sink), .out_px(out_bus.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor state.
  logic [15:0] srgb_lut [0:STEPS];
  logic [15:0] tone_copy [0:STEPS];
  weight_t     w_red, w_green, w_blue;
  logic        gamma_mix;
  logic [47:0] band_gains;

  pixel_item_t pending_q [$];
  sample_t     grey_expect_q [$];
  int          mismatches;
  int          results_seen;
  bit          tx_burst;
  bit          rx_burst;
  bit          hold_done;

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic longint unsigned int_cbrt(longint unsigned v);
    longint unsigned lo, hi, m;
    lo = 0;
    hi = 64'd1 << 21;
    while (hi - lo > 1) begin
      m = (lo + hi) >> 1;
      if (m * m * m <= v) lo = m;
      else hi = m;
    end
    return lo;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned lo, hi, m;
    lo = 0;
    hi = 64'd1 << 21;
    while (hi - lo > 1) begin
      m = (lo + hi) >> 1;
      if (m * m <= v) lo = m;
      else hi = m;
    end
    return lo;
  endfunction

  function automatic logic [15:0] srgb_encode(longint unsigned i);
    longint unsigned v, xq, c, s1, s2, p;
    longint num, den, q;
    if (i * 10000000 <= 31308 * STEPS) begin
      v = (i * 1292 * 65535 * 2 + 100 * STEPS) / (200 * STEPS);
      return (v > 65535) ? 16'hFFFF : v[15:0];
    end
    xq = ((i << 44) / STEPS) << 16;
    c = int_cbrt(xq);
    s1 = int_sqrt(c << 20);
    s2 = int_sqrt(s1 << 20);
    p = (c * s2 + (64'd1 << 19)) >> 20;
    num = (longint'(1055 * p) - 55 * (longint'(1) << 20)) * 65535;
    den = longint'(1000) << 20;
    if (num <= 0) return 16'd0;
    q = (num + den / 2) / den;
    return (q > 65535) ? 16'hFFFF : q[15:0];
  endfunction

  function automatic longint grid_of(longint v);
    longint idx;
    idx = (2 * v * STEPS + 65535) / 131070;
    return (idx > STEPS) ? STEPS : idx;
  endfunction

  function automatic longint gain_of(int k);
    longint g;
    g = longint'(band_gains[8*k +: 8]);
    if (g >= 128) g -= 256;
    if (g > 100) g = 100;
    if (g < -100) g = -100;
    return g;
  endfunction

  function automatic longint round_div(longint num, longint den);
    if (num >= 0) return (num + den / 2) / den;
    return -((-num + den / 2) / den);
  endfunction

  function automatic sample_t predict_grey(pixel_item_t it);
    longint rl, gl, bl, rs, gs, bs, grey, lin, mx, mn, delta, sat, h, f, t, a, off;
    int seg;
    rl = it.red;
    gl = it.green;
    bl = it.blue;
    rs = srgb_lut[grid_of(rl)];
    gs = srgb_lut[grid_of(gl)];
    bs = srgb_lut[grid_of(bl)];
    if (gamma_mix) begin
      grey = (w_red * rs + w_green * gs + w_blue * bs + 32768) >>> 16;
    end else begin
      lin = (w_red * rl + w_green * gl + w_blue * bl + 32768) >>> 16;
      if (lin > 65535) lin = 65535;
      grey = srgb_lut[grid_of(lin)];
    end
    mx = rs;
    mn = rs;
    if (gs > mx) mx = gs;
    if (bs > mx) mx = bs;
    if (gs < mn) mn = gs;
    if (bs < mn) mn = bs;
    delta = mx - mn;
    sat = (mx > 0) ? (delta * 65536 + mx / 2) / mx : 0;
    h = 0;
    if (delta > 0) begin
      if (mx == rs) begin
        f = round_div((gs - bs) * 65536, delta);
        h = (f < 0) ? 6 * 65536 + f : f;
      end else if (mx == gs) begin
        h = round_div((bs - rs) * 65536, delta) + 2 * 65536;
      end else begin
        h = round_div((rs - gs) * 65536, delta) + 4 * 65536;
      end
      if (h < 0) h = 0;
      if (h >= 6 * 65536) h = 6 * 65536 - 1;
    end
    seg = int'(h >>> 16);
    t = h & 65535;
    a = gain_of(seg) * (65536 - t) + gain_of((seg + 1) % 6) * t;
    off = round_div(a * sat * 65535, longint'(100) << 32);
    grey += off;
    if (grey < 0) grey = 0;
    if (grey > 65535) grey = 65535;
    return tone_copy[grid_of(grey)];
  endfunction

  task automatic report_mismatch(string what, sample_t got, sample_t want);
    $display("MISMATCH %s: got %0d want %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // Driver: the gap after each item is drawn when the item is taken off the queue.
  int tx_gap;
  always @(posedge clk) begin
    pixel_item_t nx;
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        if (in_bus.operation == OP_TABLE_WRITE) begin
          if (in_bus.table_index <= STEPS) tone_copy[in_bus.table_index] = in_bus.table_value;
        end else begin
          nx.operation = in_bus.operation;
          nx.red = in_bus.red_linear;
          nx.green = in_bus.green_linear;
          nx.blue = in_bus.blue_linear;
          grey_expect_q.push_back(predict_grey(nx));
        end
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_bus.valid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          nx = pending_q.pop_front();
          in_bus.valid <= 1'b1;
          in_bus.operation <= nx.operation;
          in_bus.red_linear <= nx.red;
          in_bus.green_linear <= nx.green;
          in_bus.blue_linear <= nx.blue;
          in_bus.table_index <= nx.tindex;
          in_bus.table_value <= nx.tvalue;
          tx_gap = tx_burst ? 0 : int'($urandom_range(0, 16));
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks results in order and paces ready, with one long hold-off.
  int rx_wait;
  always @(posedge clk) begin
    sample_t want;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        results_seen++;
        if (grey_expect_q.size() == 0) begin
          report_mismatch("unexpected grey", out_bus.grey_out, '0);
        end else begin
          want = grey_expect_q.pop_front();
          if (out_bus.grey_out !== want) report_mismatch("grey_out", out_bus.grey_out, want);
        end
        rx_wait = rx_burst ? 0 : int'($urandom_range(0, 16));
        if (!hold_done && results_seen >= 150) begin
          hold_done = 1'b1;
          rx_wait = 400;
        end
      end
      if (rx_wait > 0) begin
        rx_wait--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  task automatic push_pixel(sample_t r, sample_t g, sample_t b);
    pixel_item_t it;
    it.operation = OP_CONVERT;
    it.red = r;
    it.green = g;
    it.blue = b;
    it.tindex = tindex_t'($urandom());
    it.tvalue = sample_t'($urandom());
    pending_q.push_back(it);
  endtask

  task automatic push_table_write(tindex_t idx, sample_t val);
    pixel_item_t it;
    it.operation = OP_TABLE_WRITE;
    it.red = sample_t'($urandom());
    it.green = sample_t'($urandom());
    it.blue = sample_t'($urandom());
    it.tindex = idx;
    it.tvalue = val;
    pending_q.push_back(it);
  endtask

  function automatic sample_t pick_level();
    case ($urandom_range(0, 4))
      0: return sample_t'($urandom_range(0, 300));
      1: return sample_t'($urandom_range(65200, 65535));
      2: return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
      default: return sample_t'($urandom());
    endcase
  endfunction

  task automatic push_random(int count);
    sample_t r, g, b;
    repeat (count) begin
      r = pick_level();
      g = pick_level();
      b = pick_level();
      case ($urandom_range(0, 9))
        0: push_table_write(tindex_t'($urandom()), sample_t'($urandom()));
        1: push_pixel(r, r, r);
        2: push_pixel(r, r, b);
        3: push_pixel(r, g, g);
        4: push_pixel(r, g, r);
        default: push_pixel(r, g, b);
      endcase
    end
  endtask

  // The idle test runs twice, since the last item may leave the queue at the
  // very edge where the first test looks.
  task automatic wait_idle();
    repeat (2) begin
      do @(posedge clk);
      while (pending_q.size() != 0 || in_bus.valid || grey_expect_q.size() != 0);
      repeat (LATENCY + 6) @(posedge clk);
    end
  endtask

  task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_WEIGHT_RED:   w_red = val[16:0];
      REG_WEIGHT_GREEN: w_green = val[16:0];
      REG_WEIGHT_BLUE:  w_blue = val[16:0];
      REG_MIX_IN_GAMMA: gamma_mix = val[0];
      REG_HUE_GAINS:    band_gains = val[47:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(weight_t wr, weight_t wg, weight_t wb, logic gm,
                               logic [47:0] gains);
    write_reg(REG_WEIGHT_RED, CFG_DW'(wr));
    write_reg(REG_WEIGHT_GREEN, CFG_DW'(wg));
    write_reg(REG_WEIGHT_BLUE, CFG_DW'(wb));
    write_reg(REG_MIX_IN_GAMMA, CFG_DW'(gm));
    write_reg(REG_HUE_GAINS, gains);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [47:0] random_gains();
    logic [47:0] g;
    for (int k = 0; k < 6; k++) begin
      case ($urandom_range(0, 3))
        0: g[8*k +: 8] = 8'($urandom());
        1: g[8*k +: 8] = 8'(100);
        2: g[8*k +: 8] = 8'(-100);
        default: g[8*k +: 8] = 8'($urandom_range(0, 200) - 100);
      endcase
    end
    return g;
  endfunction

  initial begin
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    mismatches = 0;
    results_seen = 0;
    hold_done = 1'b0;
    tx_burst = 1'b0;
    rx_burst = 1'b0;
    w_red = RST_WEIGHT_RED;
    w_green = RST_WEIGHT_GREEN;
    w_blue = RST_WEIGHT_BLUE;
    gamma_mix = 1'b0;
    band_gains = '0;
    for (int i = 0; i <= STEPS; i++) begin
      srgb_lut[i] = srgb_encode(i);
      tone_copy[i] = '0;
    end
    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    apply_setting(RST_WEIGHT_RED, RST_WEIGHT_GREEN, RST_WEIGHT_BLUE, 1'b0, '0);
    // Every tone entry is loaded before any pixel can read it.
    tx_burst = 1'b1;
    for (int i = 0; i <= STEPS; i++) begin
      push_table_write(tindex_t'(i),
                       (i == 0) ? 16'h0000 : (i == STEPS) ? 16'hFFFF : 16'($urandom()));
    end
    push_table_write(13'h1FFF, sample_t'($urandom()));
    push_table_write(tindex_t'(STEPS + 1), sample_t'($urandom()));
    wait_idle();
    tx_burst = 1'b0;

    // Directed pixels: corners, primaries, secondaries, ties, the linear toe and one tone table write.
    push_pixel(16'h0000, 16'h0000, 16'h0000);
    push_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_pixel(16'hFFFF, 16'h0000, 16'h0000);
    push_pixel(16'h0000, 16'hFFFF, 16'h0000);
    push_pixel(16'h0000, 16'h0000, 16'hFFFF);
    push_pixel(16'hFFFF, 16'hFFFF, 16'h0000);
    push_pixel(16'h0000, 16'hFFFF, 16'hFFFF);
    push_pixel(16'hFFFF, 16'h0000, 16'hFFFF);
    push_pixel(16'hFFFF, 16'h0000, 16'h0100);
    push_pixel(16'd100, 16'd50, 16'd200);
    push_pixel(16'd205, 16'd206, 16'd0);
    push_pixel(16'h8000, 16'h8000, 16'h4000);
    push_pixel(16'h1234, 16'hFEDC, 16'h1234);
    push_table_write(tindex_t'(STEPS), 16'h5A5A);
    push_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
    wait_idle();

    apply_setting(17'd65536, 17'd65536, 17'd65536, 1'b1, {6{8'(100)}});
    push_pixel(16'hFFFF, 16'h0000, 16'h0000);
    push_pixel(16'h0000, 16'h0000, 16'hFFFF);
    push_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_random(300);
    wait_idle();

    apply_setting(17'd0, 17'd0, 17'd0, 1'b0, {6{8'(-100)}});
    push_pixel(16'hFFFF, 16'h0000, 16'hFFFF);
    push_random(250);
    wait_idle();

    rx_burst = 1'b1;
    apply_setting(RST_WEIGHT_RED, RST_WEIGHT_GREEN, RST_WEIGHT_BLUE, 1'b1,
                  48'h7F80_817F_8081);
    push_random(250);
    wait_idle();

    tx_burst = 1'b1;
    rx_burst = 1'b0;
    apply_setting(17'd65536, 17'd0, 17'd65536, 1'b0, random_gains());
    push_random(250);
    wait_idle();

    tx_burst = 1'b0;
    for (int ph = 0; ph < 3; ph++) begin
      rx_burst = (ph == 1);
      apply_setting(weight_t'($urandom_range(0, 65536)), weight_t'($urandom_range(0, 65536)),
                    weight_t'($urandom_range(0, 65536)), 1'($urandom_range(0, 1)),
                    random_gains());
      push_random(260);
      wait_idle();
    end

    if (mismatches == 0 && grey_expect_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #(20 * 2000000);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
